// ===== hw/rtl/casp_pkg.sv =====
// ----------------------------------------------------------------------------
// casp_pkg
// Types and constants shared by the CBOR array span parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package casp_pkg;

    localparam int POS_W = 17;

    // Result kinds
    localparam logic [1:0] KIND_SPAN = 2'd0;
    localparam logic [1:0] KIND_GOOD = 2'd1;
    localparam logic [1:0] KIND_BAD  = 2'd2;

    // CBOR major types and additional-info codes
    localparam logic [2:0] MAJOR_UINT  = 3'd0;
    localparam logic [2:0] MAJOR_BYTES = 3'd2;
    localparam logic [2:0] MAJOR_TEXT  = 3'd3;
    localparam logic [2:0] MAJOR_ARRAY = 3'd4;
    localparam logic [4:0] AI_IMM_MAX  = 5'd23;
    localparam logic [4:0] AI_EXT1     = 5'd24;
    localparam logic [4:0] AI_EXT2     = 5'd25;
    localparam logic [4:0] AI_EXT4     = 5'd26;

    typedef enum logic [2:0] {
        PH_HEAD,
        PH_HDR,
        PH_EXT,
        PH_PAY,
        PH_DONE
    } casp_phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } casp_in_t;

    typedef struct packed {
        logic [1:0]  result_kind;
        logic [4:0]  element_index;
        logic [15:0] element_offset;
        logic [15:0] element_length;
        logic [4:0]  element_count;
        logic        last;
    } casp_result_t;

    typedef struct packed {
        casp_phase_t      phase;
        logic [POS_W-1:0] byte_position;
        logic [4:0]       declared_count;
        logic [4:0]       current_element;
        logic [15:0]      element_start;
        logic [2:0]       extension_left;
        logic [31:0]      value_accumulator;
        logic             is_string_type;
        logic [31:0]      payload_left;
        logic             error_seen;
    } casp_state_t;

    localparam casp_state_t STATE_RESET = '{
        phase:             PH_HEAD,
        byte_position:     '0,
        declared_count:    '0,
        current_element:   '0,
        element_start:     '0,
        extension_left:    '0,
        value_accumulator: '0,
        is_string_type:    1'b0,
        payload_left:      '0,
        error_seen:        1'b0
    };

endpackage

`default_nettype wire

// ===== hw/rtl/cbor_array_span_parser.sv =====
// A result is written into the output queue when the byte that causes it is taken.
// Throughput: one byte per cycle; a final byte that also completes an element
// yields two results, which drain one per cycle while result_ready is high
// through a four-entry queue. The byte is taken while the queue has room for
// two results. Reset: rst_n clears the parser state and empties the queue; a
// final byte also returns the parser to its reset state.
// ----------------------------------------------------------------------------
// cbor_array_span_parser
// Parses a CBOR array of small elements one byte at a time and reports each
// element's offset and length, then a packet status on the final byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbor_array_span_parser
    import casp_pkg::*;
#(
    parameter int MAX_PACKET = 65536
)
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               item_valid,
    output logic              item_ready,
    input  wire casp_in_t     item,
    output logic              result_valid,
    input  wire               result_ready,
    output casp_result_t      result
);

    casp_state_t  state_reg;
    casp_state_t  state_next;
    casp_state_t  step_next;
    logic [1:0]   step_count;
    logic [1:0]   push_count;
    casp_result_t step_res0;
    casp_result_t step_res1;
    logic         room;
    logic         take;

    assign item_ready = room;
    assign take       = item_valid && item_ready;

    casp_step #(
        .MAX_PACKET (MAX_PACKET)
    ) u_step (
        .state      (state_reg),
        .item       (item),
        .state_next (step_next),
        .push_count (step_count),
        .result0    (step_res0),
        .result1    (step_res1)
    );

    // Hold state and push nothing unless a transaction lands
    always_comb
    begin
        state_next = take ? step_next : state_reg;
        push_count = take ? step_count : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    casp_outq u_outq (
        .clk          (clk),
        .rst_n        (rst_n),
        .push_count   (push_count),
        .push0        (step_res0),
        .push1        (step_res1),
        .room         (room),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/casp_step.sv =====
// ----------------------------------------------------------------------------
// casp_step
// Decodes one packet byte against the parser state: next state plus up to
// two results (element span, then packet status).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module casp_step
    import casp_pkg::*;
#(
    parameter int MAX_PACKET = 65536
)
(
    input  wire casp_state_t  state,
    input  wire casp_in_t     item,
    output casp_state_t       state_next,
    output logic [1:0]        push_count,
    output casp_result_t      result0,
    output casp_result_t      result1
);

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PACKET);

    logic [2:0]       major;
    logic [4:0]       ai;
    logic             in_range;
    logic [POS_W-1:0] pos_inc;

    // Pre-final state and span information
    casp_state_t      st;
    logic             span_fire;
    logic [4:0]       span_idx;
    logic [15:0]      span_off;
    logic             fin_bad;
    casp_result_t     span_res;
    casp_result_t     stat_res;

    assign major    = item.data_byte[7:5];
    assign ai       = item.data_byte[4:0];
    assign in_range = (state.byte_position < MAX_POS);
    assign pos_inc  = state.byte_position + POS_W'(1);

    // Next-state decode
    always_comb
    begin
        logic        complete;
        logic        finish;
        logic [31:0] value;
        st        = state;
        span_fire = 1'b0;
        span_idx  = state.current_element;
        span_off  = state.element_start;
        complete  = 1'b0;
        finish    = 1'b0;
        value     = '0;

        if (!in_range)
        begin
            st.error_seen = 1'b1;
        end
        else if (!state.error_seen)
        begin
            unique case (state.phase)
                PH_HEAD:
                begin
                    if (major != MAJOR_ARRAY || ai > AI_IMM_MAX)
                    begin
                        st.error_seen = 1'b1;
                    end
                    else
                    begin
                        st.declared_count  = ai;
                        st.current_element = '0;
                        st.phase           = (ai != 5'd0) ? PH_HDR : PH_DONE;
                    end
                end
                PH_HDR:
                begin
                    st.element_start = state.byte_position[15:0];
                    if (major != MAJOR_UINT && major != MAJOR_BYTES && major != MAJOR_TEXT)
                    begin
                        st.error_seen = 1'b1;
                    end
                    else
                    begin
                        st.is_string_type = (major != MAJOR_UINT);
                        if (ai <= AI_IMM_MAX)
                        begin
                            finish = 1'b1;
                            value  = {27'd0, ai};
                        end
                        else if (ai <= AI_EXT4)
                        begin
                            st.extension_left    = (ai == AI_EXT1) ? 3'd1 :
                                                   (ai == AI_EXT2) ? 3'd2 : 3'd4;
                            st.value_accumulator = '0;
                            st.phase             = PH_EXT;
                        end
                        else
                        begin
                            st.error_seen = 1'b1;
                        end
                    end
                end
                PH_EXT:
                begin
                    st.value_accumulator = {state.value_accumulator[23:0], item.data_byte};
                    st.extension_left    = state.extension_left - 3'd1;
                    if (st.extension_left == 3'd0)
                    begin
                        finish = 1'b1;
                        value  = st.value_accumulator;
                    end
                end
                PH_PAY:
                begin
                    st.payload_left = state.payload_left - 32'd1;
                    complete        = (st.payload_left == 32'd0);
                end
                PH_DONE:
                begin
                end
                default:
                begin
                end
            endcase

            // Strings with a nonzero length go on to skip payload
            if (finish)
            begin
                if (st.is_string_type && value != 32'd0)
                begin
                    st.payload_left = value;
                    st.phase        = PH_PAY;
                end
                else
                begin
                    complete = 1'b1;
                end
            end

            if (complete)
            begin
                span_fire          = 1'b1;
                span_idx           = state.current_element;
                span_off           = st.element_start;
                st.current_element = state.current_element + 5'd1;
                st.phase           = (st.current_element >= st.declared_count) ?
                                     PH_DONE : PH_HDR;
            end
        end

        if (in_range)
        begin
            st.byte_position = pos_inc;
        end
    end

    assign fin_bad = st.error_seen || (state.byte_position == '0) || (st.phase != PH_DONE);

    // Result build and packet wrap-up
    always_comb
    begin
        span_res                = '0;
        span_res.result_kind    = KIND_SPAN;
        span_res.element_index  = span_idx;
        span_res.element_offset = span_off;
        span_res.element_length = state.byte_position[15:0] - span_off + 16'd1;
        span_res.last           = !item.final_byte;

        stat_res               = '0;
        stat_res.result_kind   = fin_bad ? KIND_BAD : KIND_GOOD;
        stat_res.element_count = st.declared_count;
        stat_res.last          = 1'b1;

        result0    = span_fire ? span_res : stat_res;
        result1    = stat_res;
        push_count = 2'(span_fire) + 2'(item.final_byte);

        state_next = item.final_byte ? STATE_RESET : st;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/casp_outq.sv =====
// ----------------------------------------------------------------------------
// casp_outq
// Four-entry result queue; takes up to two results per cycle and hands out
// one per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module casp_outq
    import casp_pkg::*;
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire  [1:0]        push_count,
    input  wire casp_result_t push0,
    input  wire casp_result_t push1,
    output logic              room,
    output logic              result_valid,
    input  wire               result_ready,
    output casp_result_t      result
);

    casp_result_t mem_reg [4];
    logic [1:0]   wr_ptr_reg;
    logic [1:0]   wr_ptr_next;
    logic [1:0]   rd_ptr_reg;
    logic [1:0]   rd_ptr_next;
    logic [2:0]   count_reg;
    logic [2:0]   count_next;
    logic         pop;

    assign pop          = result_valid && result_ready;
    assign result_valid = (count_reg != 3'd0);
    assign result       = mem_reg[rd_ptr_reg];
    assign room         = (count_reg <= 3'd2);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push_count;
        rd_ptr_next = rd_ptr_reg + 2'(pop);
        count_next  = count_reg + 3'(push_count) - 3'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2)
        begin
            mem_reg[wr_ptr_reg + 2'd1] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/cbor_array_span_parser_tb.sv =====
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// cbor_array_span_parser_tb
// Streams CBOR packets into the span parser one byte per transaction and
// checks every element span and packet status against a behavioral parser
// that tracks the same byte stream. Both handshakes are paced at random, but for the final run.
// ----------------------------------------------------------------------------
module cbor_array_span_parser_tb;
    import casp_pkg::*;

    localparam int MAX_PACKET   = 65536;
    localparam int CLK_HALF     = 2;

    // Major types and additional-info codes the parser must reject
    localparam logic [2:0] MAJOR_MAP  = 3'd5;
    localparam logic [2:0] MAJOR_TAG  = 3'd6;
    localparam logic [4:0] AI_RSVD_LO = 5'd27;
    localparam logic [4:0] AI_INDEF   = 5'd31;

    logic         clk          = 1'b0;
    logic         rst_n        = 1'b0;
    logic         item_valid   = 1'b0;
    logic         item_ready;
    casp_in_t     item         = '0;
    logic         result_valid;
    logic         result_ready = 1'b0;
    casp_result_t result;

    casp_state_t  parse_st = STATE_RESET;
    casp_result_t report_buf [2];
    int           report_n;
    casp_result_t pending_reports [$];
    logic [7:0]   pkt_bytes [$];

    int src_gap_pct  = 0;
    int sink_gap_pct = 0;
    int sink_hold    = 0;
    int mismatch_cnt = 0;
    int bytes_sent   = 0;
    int packets_sent = 0;
    int span_cnt     = 0;
    int good_cnt     = 0;
    int bad_cnt      = 0;

    cbor_array_span_parser #(
        .MAX_PACKET   (MAX_PACKET)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------------
    // Behavioral parser
    // ------------------------------------------------------------------------
    function automatic void add_report(input logic [1:0] kind, input logic [4:0] idx,
                                       input logic [15:0] off, input logic [15:0] len,
                                       input logic [4:0] cnt);
        casp_result_t r;
        r.result_kind    = kind;
        r.element_index  = idx;
        r.element_offset = off;
        r.element_length = len;
        r.element_count  = cnt;
        r.last           = 1'b0;
        report_buf[report_n] = r;
        report_n++;
    endfunction

    function automatic void close_element(input logic [15:0] at);
        add_report(KIND_SPAN, parse_st.current_element, parse_st.element_start,
                   at - parse_st.element_start + 16'd1, 5'd0);
        parse_st.current_element = parse_st.current_element + 5'd1;
        if (parse_st.current_element >= parse_st.declared_count)
            parse_st.phase = PH_DONE;
        else
            parse_st.phase = PH_HDR;
    endfunction

    function automatic void value_known(input logic [31:0] v, input logic [15:0] at);
        if (parse_st.is_string_type && v != 32'd0)
        begin
            parse_st.payload_left = v;
            parse_st.phase        = PH_PAY;
        end
        else
            close_element(at);
    endfunction

    function automatic void parse_byte(input casp_in_t it);
        logic [16:0] at;
        logic [2:0]  major;
        logic [4:0]  ai;
        at       = parse_st.byte_position;
        major    = it.data_byte[7:5];
        ai       = it.data_byte[4:0];
        report_n = 0;
        if (at >= MAX_PACKET)
            parse_st.error_seen = 1'b1;
        else if (!parse_st.error_seen)
        begin
            case (parse_st.phase)
                PH_HEAD:
                begin
                    if (major != MAJOR_ARRAY || ai > AI_IMM_MAX)
                        parse_st.error_seen = 1'b1;
                    else
                    begin
                        parse_st.declared_count  = ai;
                        parse_st.current_element = 5'd0;
                        if (ai != 5'd0)
                            parse_st.phase = PH_HDR;
                        else
                            parse_st.phase = PH_DONE;
                    end
                end
                PH_HDR:
                begin
                    parse_st.element_start = at[15:0];
                    if (major != MAJOR_UINT && major != MAJOR_BYTES && major != MAJOR_TEXT)
                        parse_st.error_seen = 1'b1;
                    else
                    begin
                        parse_st.is_string_type = (major != MAJOR_UINT);
                        if (ai <= AI_IMM_MAX)
                            value_known({27'd0, ai}, at[15:0]);
                        else if (ai <= AI_EXT4)
                        begin
                            if (ai == AI_EXT1)
                                parse_st.extension_left = 3'd1;
                            else if (ai == AI_EXT2)
                                parse_st.extension_left = 3'd2;
                            else
                                parse_st.extension_left = 3'd4;
                            parse_st.value_accumulator = 32'd0;
                            parse_st.phase             = PH_EXT;
                        end
                        else
                            parse_st.error_seen = 1'b1;
                    end
                end
                PH_EXT:
                begin
                    parse_st.value_accumulator = {parse_st.value_accumulator[23:0],
                                                  it.data_byte};
                    parse_st.extension_left = parse_st.extension_left - 3'd1;
                    if (parse_st.extension_left == 3'd0)
                        value_known(parse_st.value_accumulator, at[15:0]);
                end
                PH_PAY:
                begin
                    parse_st.payload_left = parse_st.payload_left - 32'd1;
                    if (parse_st.payload_left == 32'd0)
                        close_element(at[15:0]);
                end
                default:
                    ;
            endcase
        end
        // saturate the position once the packet is over length
        if (at < MAX_PACKET)
            parse_st.byte_position = at + 17'd1;
        if (it.final_byte)
        begin
            if (parse_st.error_seen || parse_st.byte_position < 2 || parse_st.phase != PH_DONE)
                add_report(KIND_BAD, 5'd0, 16'd0, 16'd0, parse_st.declared_count);
            else
                add_report(KIND_GOOD, 5'd0, 16'd0, 16'd0, parse_st.declared_count);
            parse_st = STATE_RESET;
        end
        if (report_n > 0)
            report_buf[report_n - 1].last = 1'b1;
        for (int k = 0; k < report_n; k++)
            pending_reports.push_back(report_buf[k]);
    endfunction

    // ------------------------------------------------------------------------
    // Input tracking, result checking and result-side pacing
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        casp_result_t want;
        if (rst_n)
        begin
            if (item_valid && item_ready)
                parse_byte(item);
            if (result_valid && result_ready)
            begin
                if (result.result_kind == KIND_SPAN)
                    span_cnt++;
                else if (result.result_kind == KIND_GOOD)
                    good_cnt++;
                else
                    bad_cnt++;
                if (pending_reports.size() == 0)
                begin
                    if (mismatch_cnt < 10)
                        $display("%0t: unexpected result kind %0d idx %0d off %0d len %0d",
                                 $time, result.result_kind, result.element_index,
                                 result.element_offset, result.element_length,
                                 " cnt %0d last %0d", result.element_count, result.last);
                    mismatch_cnt++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (result.result_kind    !== want.result_kind    ||
                        result.element_index  !== want.element_index  ||
                        result.element_offset !== want.element_offset ||
                        result.element_length !== want.element_length ||
                        result.element_count  !== want.element_count  ||
                        result.last           !== want.last)
                    begin
                        if (mismatch_cnt < 10)
                        begin
                            $display("%0t: expected kind %0d idx %0d off %0d len %0d",
                                     $time, want.result_kind, want.element_index,
                                     want.element_offset, want.element_length,
                                     " cnt %0d last %0d", want.element_count, want.last);
                            $display("%0t:      got kind %0d idx %0d off %0d len %0d",
                                     $time, result.result_kind, result.element_index,
                                     result.element_offset, result.element_length,
                                     " cnt %0d last %0d", result.element_count,
                                     result.last);
                        end
                        mismatch_cnt++;
                    end
                end
            end
            if (sink_hold > 0)
            begin
                result_ready <= 1'b0;
                sink_hold--;
            end
            else if (sink_gap_pct != 0 && $urandom_range(1, 100) <= sink_gap_pct)
            begin
                result_ready <= 1'b0;
                sink_hold = $urandom_range(0, 15);
            end
            else
                result_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] rand_byte();
        logic [7:0] b;
        b = 8'($urandom);
        return b;
    endfunction

    function automatic int pick_gap_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 5;
            default: return 30;
        endcase
    endfunction

    function automatic int pick_ext_width(input bit allow_imm);
        int sel;
        sel = allow_imm ? $urandom_range(0, 3) : $urandom_range(1, 3);
        return (sel == 3) ? 4 : sel;
    endfunction

    // Append a header with an immediate value (ext_bytes 0) or big-endian extension
    task automatic push_header(input logic [2:0] maj, input int ext_bytes,
                               input logic [31:0] val);
        logic [4:0] ai;
        case (ext_bytes)
            1:       ai = AI_EXT1;
            2:       ai = AI_EXT2;
            4:       ai = AI_EXT4;
            default: ai = val[4:0];
        endcase
        pkt_bytes.push_back({maj, ai});
        for (int k = ext_bytes - 1; k >= 0; k--)
            pkt_bytes.push_back(val[8*k +: 8]);
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        casp_in_t it;
        if (src_gap_pct != 0 && $urandom_range(1, 100) <= src_gap_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        it.data_byte  = b;
        it.final_byte = fin;
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        bytes_sent++;
    endtask

    // Send the staged packet, final flag on its last byte, then clear it
    task automatic send_packet();
        for (int k = 0; k < pkt_bytes.size(); k++)
            send_byte(pkt_bytes[k], k == pkt_bytes.size() - 1);
        packets_sent++;
        pkt_bytes.delete();
    endtask

    task automatic build_random_packet();
        int         n_elem;
        int         width;
        int         len;
        logic [2:0] maj;
        if ($urandom_range(0, 15) == 0)
            n_elem = 23;
        else if ($urandom_range(0, 3) == 0)
            n_elem = $urandom_range(0, 23);
        else
            n_elem = $urandom_range(0, 4);
        push_header(MAJOR_ARRAY, 0, n_elem);
        for (int e = 0; e < n_elem; e++)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                width = pick_ext_width(1'b1);
                push_header(MAJOR_UINT, width, (width == 0) ? $urandom_range(0, 23) : $urandom);
            end
            else
            begin
                maj   = ($urandom_range(0, 1) == 0) ? MAJOR_BYTES : MAJOR_TEXT;
                len   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                width = pick_ext_width(len <= AI_IMM_MAX);
                push_header(maj, width, len);
                repeat (len) pkt_bytes.push_back(rand_byte());
            end
        end
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) pkt_bytes.push_back(rand_byte());
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_packets();
        src_gap_pct  = 20;
        sink_gap_pct = 20;
        // lone empty array head: complete but too short
        push_header(MAJOR_ARRAY, 0, 0);
        send_packet();
        // one immediate uint; span and status land on the same byte
        push_header(MAJOR_ARRAY, 0, 1);
        push_header(MAJOR_UINT, 0, 0);
        send_packet();
        // head with the wrong major type
        push_header(MAJOR_MAP, 0, 1);
        push_header(MAJOR_UINT, 0, 0);
        send_packet();
        // array count above the immediate range
        push_header(MAJOR_ARRAY, 1, 30);
        send_packet();
        // four-byte uint, zero-length text via extension, one-byte string, trailer
        push_header(MAJOR_ARRAY, 0, 3);
        push_header(MAJOR_UINT, 4, 32'hFFFF_FFFF);
        push_header(MAJOR_TEXT, 1, 0);
        push_header(MAJOR_BYTES, 0, 1);
        pkt_bytes.push_back(8'h00);
        pkt_bytes.push_back(8'hFF);
        send_packet();
        // reserved additional info after a two-byte uint
        push_header(MAJOR_ARRAY, 0, 2);
        push_header(MAJOR_UINT, 2, 1);
        push_header(MAJOR_UINT, 0, 32'(AI_RSVD_LO));
        send_packet();
        // zero-length string, then the packet ends one element short
        push_header(MAJOR_ARRAY, 0, 2);
        push_header(MAJOR_BYTES, 0, 0);
        send_packet();
        // element with an unsupported major type
        push_header(MAJOR_ARRAY, 0, 1);
        push_header(MAJOR_TAG, 0, 0);
        send_packet();
        // indefinite-length string is not supported
        push_header(MAJOR_ARRAY, 0, 1);
        push_header(MAJOR_BYTES, 0, 32'(AI_INDEF));
        send_packet();
    endtask

    // Mostly well-formed packets; some cut short, corrupted or pure noise
    task automatic test_random_packets(input int budget, input bit paced);
        int first;
        int pick;
        first = bytes_sent;
        while (bytes_sent - first < budget)
        begin
            src_gap_pct  = paced ? pick_gap_pct() : 0;
            sink_gap_pct = paced ? pick_gap_pct() : 0;
            build_random_packet();
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                if (pkt_bytes.size() > 1)
                    repeat ($urandom_range(1, pkt_bytes.size() - 1))
                        pkt_bytes.delete(pkt_bytes.size() - 1);
            end
            else if (pick < 22)
                pkt_bytes[$urandom_range(0, pkt_bytes.size() - 1)] = rand_byte();
            else if (pick < 30)
            begin
                pkt_bytes.delete();
                repeat ($urandom_range(1, 8)) pkt_bytes.push_back(rand_byte());
            end
            send_packet();
        end
    endtask

    initial
    begin
        int wait_cnt;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_packets();
        test_random_packets(1600, 1'b1);
        // finish with both sides running flat out
        test_random_packets(300, 1'b0);

        item_valid <= 1'b0;
        wait_cnt = 0;
        while (pending_reports.size() != 0 && wait_cnt < 4000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (10) @(posedge clk);
        mismatch_cnt += pending_reports.size();

        $display("Sent %0d bytes in %0d packets, directed and random, with random stalls",
                 bytes_sent, packets_sent);
        $display("Checked %0d element spans, %0d well-formed and %0d malformed statuses",
                 span_cnt, good_cnt, bad_cnt);
        if (mismatch_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #(5_000_000);
        $display("Mismatches found");
        $finish;
    end

endmodule
